// File: hw/rtl/dsts_pkg.sv
// Package for the duration text parser: character codes, unit multipliers
// and the terminator-to-multiplier lookup. No dependencies.
package dsts_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned HALF_W  = VALUE_W / 2;

   localparam int unsigned SECS_MIN  = 60;
   localparam int unsigned SECS_HOUR = 3600;
   localparam int unsigned SECS_DAY  = 86400;
   localparam int unsigned SECS_WEEK = 7 * SECS_DAY;
   localparam int unsigned SECS_YEAR = 365 * SECS_DAY;
   localparam int unsigned DEC_BASE  = 10;

   // Width of the largest multiplier (one year in seconds).
   localparam int unsigned MUL_W  = $clog2(SECS_YEAR + 1);
   localparam int unsigned PLO_W  = HALF_W + MUL_W;
   localparam int unsigned DIGIT_W = 4;

   // Largest segment value that can still take one more digit, and the
   // largest digit allowed when the value sits exactly at that limit.
   localparam logic [VALUE_W-1:0] DIGIT_LIMIT    = {VALUE_W{1'b1}} / DEC_BASE;
   localparam logic [DIGIT_W-1:0] MAX_LAST_DIGIT =
      DIGIT_W'({VALUE_W{1'b1}} % DEC_BASE);

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;
   localparam logic [CHAR_W-1:0] CHAR_Y     = 8'h79;
   localparam logic [CHAR_W-1:0] CHAR_W_UNIT = 8'h77;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;
   localparam logic [CHAR_W-1:0] CHAR_H     = 8'h68;
   localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6d;

   // Multiplier chosen by a segment terminator; the first colon is hours,
   // later colons are minutes, anything unknown counts as seconds.
   function automatic logic [MUL_W-1:0] char_multiplier(
      input logic [CHAR_W-1:0] ch,
      input logic              colon_seen
   );
      logic [MUL_W-1:0] mul;
      case (ch)
         CHAR_Y:      mul = MUL_W'(SECS_YEAR);
         CHAR_W_UNIT: mul = MUL_W'(SECS_WEEK);
         CHAR_D:      mul = MUL_W'(SECS_DAY);
         CHAR_H:      mul = MUL_W'(SECS_HOUR);
         CHAR_M:      mul = MUL_W'(SECS_MIN);
         CHAR_COLON:  mul = colon_seen ? MUL_W'(SECS_MIN) : MUL_W'(SECS_HOUR);
         default:     mul = MUL_W'(1);
      endcase
      return mul;
   endfunction

endpackage

// File: hw/rtl/duration_string_to_seconds_top.sv
// Duration text parser top level: parse stage, split multiply, product
// merge, accumulate and result register. Depends on dsts_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | req_char_code, req_last_char
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_total_seconds
//
// One character transaction is taken every cycle while req_stall is low.
// A result passes the stage 1, 2 and 3 registers and the result register
// after its last character; the depth is set by the 64 x 25 segment multiply,
// done as two 32-bit partial products in one stage, merged in the next, and
// summed into the running total after that. Reset is synchronous and clears
// the parse state, every stage valid bit and the running total. A stalled
// result holds in the output register while upstream stages keep filling
// bubbles; req_stall rises only when the first stage is occupied and cannot move.
module duration_string_to_seconds_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dsts_pkg::CHAR_W-1:0]       req_char_code,
   input  logic                              req_last_char,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dsts_pkg::VALUE_W-1:0]      rsp_total_seconds
);

   localparam int unsigned VW = dsts_pkg::VALUE_W;
   localparam int unsigned HW = dsts_pkg::HALF_W;
   localparam int unsigned MW = dsts_pkg::MUL_W;
   localparam int unsigned PW = dsts_pkg::PLO_W;
   localparam int unsigned DW = dsts_pkg::DIGIT_W;

   // ---------------------------------------------------------------------
   // Parse state (one open segment plus text-wide flags)
   // ---------------------------------------------------------------------
   logic [VW-1:0] seg_value_ff, seg_value_in;
   logic          seg_has_digit_ff, seg_has_digit_in;
   logic          seg_overflow_ff, seg_overflow_in;
   logic          colon_seen_ff, colon_seen_in;
   logic          parse_stopped_ff, parse_stopped_in;

   // Stage 1: closed segment value and multiplier
   logic          s1_valid_ff;
   logic          s1_last_ff;
   logic [VW-1:0] s1_value_ff;
   logic [MW-1:0] s1_mul_ff;

   // Stage 2: partial products
   logic          s2_valid_ff;
   logic          s2_last_ff;
   logic [PW-1:0] s2_plo_ff;
   logic [HW-1:0] s2_phi_ff;

   // Stage 3: merged product
   logic          s3_valid_ff;
   logic          s3_last_ff;
   logic [VW-1:0] s3_prod_ff;

   // Accumulator and result register
   logic [VW-1:0] total_ff;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_total_ff;

   logic req_accept;
   logic out_free, adv3, adv2, adv1;
   logic s3_free, s2_free, s1_free;

   // Advance a stage when the one after it is empty or moving on. A
   // non-last item in stage 3 only feeds the accumulator, so it never waits.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign adv3     = s3_valid_ff && (!s3_last_ff || out_free);
   assign s3_free  = !s3_valid_ff || adv3;
   assign adv2     = s2_valid_ff && s3_free;
   assign s2_free  = !s2_valid_ff || adv2;
   assign adv1     = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || adv1;

   assign req_stall  = !s1_free;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Parse logic
   // ---------------------------------------------------------------------
   logic          is_digit;
   logic [DW-1:0] digit;
   logic          digit_overflows;
   logic [VW-1:0] seg_step;
   logic          add_en;
   logic [VW-1:0] add_value;
   logic [MW-1:0] add_mul;

   assign is_digit = (req_char_code >= dsts_pkg::CHAR_ZERO) &&
                     (req_char_code <= dsts_pkg::CHAR_NINE);
   assign digit    = DW'(req_char_code - dsts_pkg::CHAR_ZERO);
   assign digit_overflows = (seg_value_ff > dsts_pkg::DIGIT_LIMIT) ||
                            ((seg_value_ff == dsts_pkg::DIGIT_LIMIT) &&
                             (digit > dsts_pkg::MAX_LAST_DIGIT));
   // value * 10 + digit as shifts and adds
   assign seg_step = (seg_value_ff << 3) + (seg_value_ff << 1) + VW'(digit);

   always_comb begin
      seg_value_in     = seg_value_ff;
      seg_has_digit_in = seg_has_digit_ff;
      seg_overflow_in  = seg_overflow_ff;
      colon_seen_in    = colon_seen_ff;
      parse_stopped_in = parse_stopped_ff;
      add_en           = 1'b0;
      add_value        = seg_value_ff;
      add_mul          = MW'(1);

      if (!parse_stopped_ff) begin
         if (is_digit) begin
            if (!seg_overflow_ff) begin
               if (digit_overflows) begin
                  seg_overflow_in = 1'b1;
               end else begin
                  seg_value_in = seg_step;
               end
            end
            seg_has_digit_in = 1'b1;
            // End of text on a digit closes the segment as plain seconds.
            if (req_last_char && !seg_overflow_in) begin
               add_en    = 1'b1;
               add_value = seg_value_in;
            end
         end else begin
            // Empty or overflowed segment: drop it and stop parsing.
            if (!seg_has_digit_ff || seg_overflow_ff) begin
               parse_stopped_in = 1'b1;
            end else begin
               add_en  = 1'b1;
               add_mul = dsts_pkg::char_multiplier(req_char_code, colon_seen_ff);
               if (req_char_code == dsts_pkg::CHAR_COLON) begin
                  colon_seen_in = 1'b1;
               end
            end
            seg_value_in     = '0;
            seg_has_digit_in = 1'b0;
            seg_overflow_in  = 1'b0;
            // NUL ends the text in all but name.
            if (req_char_code == dsts_pkg::CHAR_NUL) begin
               parse_stopped_in = 1'b1;
            end
         end
      end

      // The last character starts a fresh text afterwards.
      if (req_last_char) begin
         seg_value_in     = '0;
         seg_has_digit_in = 1'b0;
         seg_overflow_in  = 1'b0;
         colon_seen_in    = 1'b0;
         parse_stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_value_ff     <= '0;
         seg_has_digit_ff <= 1'b0;
         seg_overflow_ff  <= 1'b0;
         colon_seen_ff    <= 1'b0;
         parse_stopped_ff <= 1'b0;
      end else if (req_accept) begin
         seg_value_ff     <= seg_value_in;
         seg_has_digit_ff <= seg_has_digit_in;
         seg_overflow_ff  <= seg_overflow_in;
         colon_seen_ff    <= colon_seen_in;
         parse_stopped_ff <= parse_stopped_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the closed segment; a zero multiplier adds nothing
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff  <= req_last_char;
         s1_value_ff <= add_value;
         s1_mul_ff   <= add_en ? add_mul : '0;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: split multiply; only the low half of the upper product counts
   // ---------------------------------------------------------------------
   logic [PW-1:0]   plo_in;
   logic [PW-1:0]   phi_full;
   logic [HW-1:0]   phi_in;

   assign plo_in   = PW'(s1_value_ff[HW-1:0]) * PW'(s1_mul_ff);
   assign phi_full = PW'(s1_value_ff[VW-1:HW]) * PW'(s1_mul_ff);
   assign phi_in   = phi_full[HW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= adv1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s2_last_ff <= s1_last_ff;
         s2_plo_ff  <= plo_in;
         s2_phi_ff  <= phi_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: merge partial products modulo 2^64
   // ---------------------------------------------------------------------
   logic [VW-1:0] prod_in;

   assign prod_in = VW'(s2_plo_ff) + {s2_phi_ff, {HW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= adv2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s3_last_ff <= s2_last_ff;
         s3_prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // Accumulate; the last item of a text loads the result and clears total
   // ---------------------------------------------------------------------
   logic [VW-1:0] total_sum;

   assign total_sum = total_ff + s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (adv3) begin
         total_ff <= s3_last_ff ? '0 : total_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= adv3 && s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s3_last_ff) begin
         rsp_total_ff <= total_sum;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_total_seconds = rsp_total_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_stall_needs_occupied: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s3_last_ff))
      else $error("input stalled with a free slot in the pipeline");

   a_last_clears_parse: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_char) |=>
         (seg_value_ff == '0 && !seg_has_digit_ff && !colon_seen_ff &&
          !parse_stopped_ff))
      else $error("parse state not cleared after last character");

   a_overflow_has_digit: assert property (@(posedge clock) disable iff (reset)
      seg_overflow_ff |-> seg_has_digit_ff)
      else $error("segment overflow without digits");

   a_stopped_seg_clear: assert property (@(posedge clock) disable iff (reset)
      parse_stopped_ff |-> (!seg_has_digit_ff && seg_value_ff == '0))
      else $error("open segment while parsing is stopped");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff && s3_last_ff))
      else $error("result without a last item in the accumulate stage");

endmodule
